// File: rtl/wsd_pkg.sv
package wsd_pkg;

  localparam int SLOT_COUNT  = 4096;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int PTR_BITS    = SLOT_BITS + 1;
  localparam int PTR_RANGE   = 2 * SLOT_COUNT;
  localparam int OP_BITS     = 2;

  localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(PTR_RANGE - 1);
  localparam logic [PTR_BITS-1:0] PTR_SLOTS = PTR_BITS'(SLOT_COUNT);

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2
  } op_t;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [SLOT_BITS-1:0]   addr;
    logic [HANDLE_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic got;
    logic rejected;
    logic empty;
  } res_flags_t;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] s;
    s = (p >= PTR_SLOTS) ? (p - PTR_SLOTS) : p;
    return s[SLOT_BITS-1:0];
  endfunction

endpackage

// File: rtl/wsd_req_if.sv
interface wsd_req_if import wsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     op;
  logic [HANDLE_BITS-1:0] task_handle;

  modport source (output valid, output op, output task_handle, input ready);
  modport sink (input valid, input op, input task_handle, output ready);
endinterface

// File: rtl/wsd_rsp_if.sv
interface wsd_rsp_if import wsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   got_task;
  logic [HANDLE_BITS-1:0] handle_out;
  logic                   push_rejected;
  logic                   now_empty;

  modport source (output valid, output got_task, output handle_out, output push_rejected,
                  output now_empty, input ready);
  modport sink (input valid, input got_task, input handle_out, input push_rejected,
                input now_empty, output ready);
endinterface

// File: rtl/wsd_ram.sv
module wsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/wsd_ptr.sv
module wsd_ptr import wsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [OP_BITS-1:0]     op,
  input  logic [HANDLE_BITS-1:0] task_handle,
  output mem_req_t               mem_req,
  output res_flags_t             flags
);

  logic [PTR_BITS-1:0] top;
  logic [PTR_BITS-1:0] bottom;
  logic [PTR_BITS-1:0] top_next;
  logic [PTR_BITS-1:0] bottom_next;
  logic [PTR_BITS-1:0] occ;
  logic [PTR_BITS-1:0] top_inc;
  logic [PTR_BITS-1:0] bottom_inc;
  logic [PTR_BITS-1:0] bottom_dec;
  logic                full;
  logic                empty;

  assign occ        = (bottom >= top) ? (bottom - top) : (bottom + PTR_SLOTS + PTR_SLOTS - top);
  assign full       = (occ >= PTR_SLOTS);
  assign empty      = (occ == '0);
  assign top_inc    = (top == PTR_LAST) ? '0 : (top + PTR_BITS'(1));
  assign bottom_inc = (bottom == PTR_LAST) ? '0 : (bottom + PTR_BITS'(1));
  assign bottom_dec = (bottom == '0) ? PTR_LAST : (bottom - PTR_BITS'(1));

  always_comb begin
    top_next      = top;
    bottom_next   = bottom;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = slot_of(bottom);
    mem_req.wdata = task_handle;
    flags.got      = 1'b0;
    flags.rejected = 1'b0;
    case (op_t'(op))
      OP_PUSH: begin
        if (full) begin
          flags.rejected = 1'b1;
        end else begin
          mem_req.we  = acc;
          bottom_next = bottom_inc;
        end
      end
      OP_POP: begin
        if (!empty) begin
          mem_req.re   = acc;
          mem_req.addr = slot_of(bottom_dec);
          bottom_next  = bottom_dec;
          flags.got    = 1'b1;
        end
      end
      OP_STEAL: begin
        if (!empty) begin
          mem_req.re   = acc;
          mem_req.addr = slot_of(top);
          top_next     = top_inc;
          flags.got    = 1'b1;
        end
      end
      default: begin
      end
    endcase
    flags.empty = (top_next == bottom_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '0;
      bottom <= '0;
    end else if (acc) begin
      top    <= top_next;
      bottom <= bottom_next;
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= PTR_SLOTS)
    else $error("deque occupancy exceeds the slot count");
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    acc && flags.rejected |-> full && !mem_req.we)
    else $error("push rejected while the ring had room");
  a_push_moves: assert property (@(posedge clk) disable iff (rst)
    acc && mem_req.we |=> occ == $past(occ) + PTR_BITS'(1))
    else $error("accepted push did not grow the deque by one");
  a_take_moves: assert property (@(posedge clk) disable iff (rst)
    acc && flags.got |=> occ == $past(occ) - PTR_BITS'(1))
    else $error("pop or steal did not shrink the deque by one");
`endif

endmodule

// File: rtl/work_stealing_deque.sv
// Work-stealing task deque over a ring of SLOT_COUNT handles: push and pop work at the bottom,
// steal takes the oldest handle from the top, and every request transaction yields exactly
// one response transaction. A push to a full ring is dropped and flagged. The response
// appears in the cycle after the request is accepted, as the slot memory read is registered, and
// a new request is taken every cycle while the response side keeps up, so the sustained
// rate is one operation per cycle. No clearing pass is needed after reset.
module work_stealing_deque import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wsd_req_if.sink    req,
  wsd_rsp_if.source  rsp
);

  mem_req_t               mem_req;
  res_flags_t             flags;
  res_flags_t             pend;
  logic                   pend_valid;
  logic                   acc;
  logic [HANDLE_BITS-1:0] rdata;

  assign req.ready = !pend_valid || rsp.ready;
  assign acc       = req.valid && req.ready;

  wsd_ptr u_ptr (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .op          (req.op),
    .task_handle (req.task_handle),
    .mem_req     (mem_req),
    .flags       (flags)
  );

  wsd_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req.ready) begin
      pend_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend <= flags;
    end
  end

  assign rsp.valid         = pend_valid;
  assign rsp.got_task      = pend.got;
  assign rsp.handle_out    = pend.got ? rdata : '0;
  assign rsp.push_rejected = pend.rejected;
  assign rsp.now_empty     = pend.empty;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !rsp.ready |=> pend_valid && $stable(rsp.handle_out))
    else $error("stalled response lost or changed");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !(pend.got && pend.rejected))
    else $error("response both returned a handle and rejected a push");
  a_noread_stall: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !rsp.ready |-> !mem_req.re || !acc)
    else $error("memory read issued while a response was stalled");
`endif

endmodule

// File: verif/deque_checker.sv
module deque_checker (
  input  logic clk,
  input  logic rst,
  wsd_req_if   req,
  wsd_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  typedef struct packed {
    logic                   got;
    logic [HANDLE_BITS-1:0] handle;
    logic                   rejected;
    logic                   empty;
  } deque_result_t;

  deque_result_t          expected_q[$];
  logic [HANDLE_BITS-1:0] slots [SLOT_COUNT];
  logic [PTR_BITS-1:0]    top_ptr = '0;
  logic [PTR_BITS-1:0]    bottom_ptr = '0;
  int                     failures = 0;

  // Pointers run modulo twice the ring size, so their difference tells full from empty.
  task automatic apply_deque_op(input logic [OP_BITS-1:0] op,
                                input logic [HANDLE_BITS-1:0] handle,
                                output deque_result_t res);
    logic [PTR_BITS-1:0] fill;
    fill = bottom_ptr - top_ptr;
    res = '0;
    case (op)
      OP_PUSH: begin
        if (fill == PTR_SLOTS) begin
          res.rejected = 1'b1;
        end else begin
          slots[bottom_ptr[SLOT_BITS-1:0]] = handle;
          bottom_ptr = bottom_ptr + PTR_BITS'(1);
        end
      end
      OP_POP: begin
        if (fill != '0) begin
          bottom_ptr = bottom_ptr - PTR_BITS'(1);
          res.handle = slots[bottom_ptr[SLOT_BITS-1:0]];
          res.got = 1'b1;
        end
      end
      OP_STEAL: begin
        if (fill != '0) begin
          res.handle = slots[top_ptr[SLOT_BITS-1:0]];
          top_ptr = top_ptr + PTR_BITS'(1);
          res.got = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.empty = (top_ptr == bottom_ptr);
  endtask

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  task automatic check_field(input string field, input logic [HANDLE_BITS-1:0] want,
                             input logic [HANDLE_BITS-1:0] seen);
    if (seen !== want) begin
      log_failure($sformatf("%s mismatch: expected %0h, got %0h", field, want, seen));
    end
  endtask

  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst) begin
      top_ptr = '0;
      bottom_ptr = '0;
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        apply_deque_op(req.op, req.task_handle, want);
        expected_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          log_failure("response transaction with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("got_task", HANDLE_BITS'(want.got), HANDLE_BITS'(rsp.got_task));
          check_field("handle_out", want.handle, rsp.handle_out);
          check_field("push_rejected", HANDLE_BITS'(want.rejected),
                      HANDLE_BITS'(rsp.push_rejected));
          check_field("now_empty", HANDLE_BITS'(want.empty), HANDLE_BITS'(rsp.now_empty));
        end
      end
    end
    mismatches <= failures;
    pending <= expected_q.size();
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam logic [OP_BITS-1:0] OP_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rsp_ready = 1'b0;
  int   send_burst = 0;
  int   recv_burst = 0;
  int   ready_hold = 0;
  int   mismatches;
  int   pending;

  wsd_req_if req ();
  wsd_rsp_if rsp ();

  assign rsp.ready = rsp_ready;

  work_stealing_deque i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  deque_checker i_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 64);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      rsp_ready <= 1'b0;
      ready_hold--;
    end else begin
      rsp_ready <= 1'b1;
      ready_hold = pick_gap(recv_burst);
    end
  end

  task automatic send_op(input logic [OP_BITS-1:0] op, input logic [HANDLE_BITS-1:0] handle);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.task_handle <= handle;
    do @(posedge clk); while (!req.ready);
  endtask

  // A small share of picks are no-ops; whatever is left after that and the push and pop shares goes to steal.
  task automatic send_random_op(input int push_pct, input int pop_pct);
    int                     pick;
    logic [OP_BITS-1:0]     op;
    logic [HANDLE_BITS-1:0] handle;
    pick = $urandom_range(99);
    if (pick < 2) op = OP_NOP;
    else if (pick < 2 + push_pct) op = OP_PUSH;
    else if (pick < 2 + push_pct + pop_pct) op = OP_POP;
    else op = OP_STEAL;
    pick = $urandom_range(9);
    if (pick == 0) handle = '0;
    else if (pick == 1) handle = '1;
    else handle = HANDLE_BITS'($urandom);
    send_op(op, handle);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int push_pct;
    int pop_pct;
    req.valid <= 1'b0;
    req.op <= OP_PUSH;
    req.task_handle <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_STEAL, 16'h1234);
    send_op(OP_POP, 16'hFFFF);
    send_op(OP_NOP, 16'h0000);
    send_op(OP_PUSH, 16'h0000);
    send_op(OP_PUSH, 16'hFFFF);
    send_op(OP_PUSH, 16'hA5A5);
    send_op(OP_PUSH, 16'h5A5A);
    send_op(OP_NOP, 16'hFFFF);
    send_op(OP_STEAL, 16'h0000);
    send_op(OP_POP, 16'h0000);
    send_op(OP_STEAL, 16'hFFFF);
    send_op(OP_POP, 16'hFFFF);
    send_op(OP_POP, 16'h0000);
    send_op(OP_STEAL, 16'h0000);
    send_op(OP_PUSH, 16'h8001);
    send_op(OP_POP, 16'h0000);
    send_op(OP_PUSH, 16'h7FFE);
    send_op(OP_STEAL, 16'h0000);
    send_op(OP_NOP, 16'h5555);
    wait_drained();

    for (int chunk = 0; chunk < 31; chunk++) begin
      push_pct = $urandom_range(30, 65);
      pop_pct = (98 - push_pct) / 2;
      repeat (50) send_random_op(push_pct, pop_pct);
    end

    req.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
